>>> sv/rei_pkg.sv
package rei_pkg;

    localparam int PADDR_W = 4;

    // register word indices, taken from paddr[3:2]
    localparam logic [1:0] REG_DEBOUNCE_TICKS    = 2'd0;
    localparam logic [1:0] REG_PULSES_PER_DETENT = 2'd1;
    localparam logic [1:0] REG_BUTTON_ENABLE     = 2'd2;

    localparam logic [7:0] DEBOUNCE_TICKS_RST    = 8'd25;
    localparam logic [2:0] PULSES_PER_DETENT_RST = 3'd4;
    localparam logic       BUTTON_ENABLE_RST     = 1'b1;

    localparam logic [1:0] LAST_AB_RST = 2'b11;

    localparam logic signed [15:0] STEPS_MAX = 16'sh7FFF;
    localparam logic signed [15:0] STEPS_MIN = -16'sh8000;
    localparam logic [7:0]         PRESSES_MAX = 8'hFF;
    localparam logic [7:0]         HOLD_MAX    = 8'hFF;

    // old/new A/B transition codes
    localparam logic [3:0] TR_CW_0  = 4'b0001;
    localparam logic [3:0] TR_CW_1  = 4'b0111;
    localparam logic [3:0] TR_CW_2  = 4'b1110;
    localparam logic [3:0] TR_CW_3  = 4'b1000;
    localparam logic [3:0] TR_CCW_0 = 4'b0010;
    localparam logic [3:0] TR_CCW_1 = 4'b1011;
    localparam logic [3:0] TR_CCW_2 = 4'b1101;
    localparam logic [3:0] TR_CCW_3 = 4'b0100;

    typedef enum logic [1:0] {
        MOVE_NONE = 2'b00,
        MOVE_CW   = 2'b01,
        MOVE_CCW  = 2'b10
    } move_t;

    typedef struct packed {
        logic [7:0] debounce_ticks;
        logic [2:0] pulses_per_detent;
        logic       button_enable;
    } cfg_t;

    typedef struct packed {
        logic pin_a;
        logic pin_b;
        logic button_pressed;
        logic ms_tick;
        logic take_steps;
        logic take_press;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] steps_taken;
        logic               press_taken;
        logic signed [15:0] steps_waiting;
        logic [7:0]         presses_waiting;
        logic               button_stable;
    } result_t;

    function automatic move_t decode_move(input logic [3:0] code);
        move_t m;
        case (code) inside
            TR_CW_0, TR_CW_1, TR_CW_2, TR_CW_3:     m = MOVE_CW;
            TR_CCW_0, TR_CCW_1, TR_CCW_2, TR_CCW_3: m = MOVE_CCW;
            default:                                m = MOVE_NONE;
        endcase
        return m;
    endfunction

endpackage

>>> sv/rotary_encoder_interface_core.sv
// An accepted sample word goes through the sample register, then the result register.
// Throughput: one sample word per cycle; s_ready drops only while both the
// sample register and the result register are full and m_ready is low.
// Reset (aresetn low, synchronous): pipeline emptied, encoder and button state
// cleared, registers back to debounce 25, 4 pulses per detent, button fitted.
module rotary_encoder_interface_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rei_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_pin_a,
    input  logic                         s_pin_b,
    input  logic                         s_button_pressed,
    input  logic                         s_ms_tick,
    input  logic                         s_take_steps,
    input  logic                         s_take_press,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [15:0]           m_steps_taken,
    output logic                         m_press_taken,
    output logic signed [15:0]           m_steps_waiting,
    output logic [7:0]                   m_presses_waiting,
    output logic                         m_button_stable
);

    rei_pkg::cfg_t    cfg;
    rei_pkg::sample_t in_reg;
    logic             in_valid_reg;
    rei_pkg::result_t out_reg, res;
    logic             out_valid_reg;
    logic             adv;

    // a sample moves on whenever the result register is free or being drained
    assign adv     = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;

    rei_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rei_enc u_enc (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .adv               (adv),
        .pulses_per_detent (cfg.pulses_per_detent),
        .pin_a             (in_reg.pin_a),
        .pin_b             (in_reg.pin_b),
        .take_steps        (in_reg.take_steps),
        .steps_taken       (res.steps_taken),
        .steps_waiting     (res.steps_waiting)
    );

    rei_btn u_btn (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .adv             (adv),
        .cfg             (cfg),
        .button_pressed  (in_reg.button_pressed),
        .ms_tick         (in_reg.ms_tick),
        .take_press      (in_reg.take_press),
        .press_taken     (res.press_taken),
        .presses_waiting (res.presses_waiting),
        .button_stable   (res.button_stable)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) in_valid_reg <= s_valid;
            if (adv) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg.pin_a          <= s_pin_a;
            in_reg.pin_b          <= s_pin_b;
            in_reg.button_pressed <= s_button_pressed;
            in_reg.ms_tick        <= s_ms_tick;
            in_reg.take_steps     <= s_take_steps;
            in_reg.take_press     <= s_take_press;
        end
        if (adv) out_reg <= res;
    end

    assign m_valid           = out_valid_reg;
    assign m_steps_taken     = out_reg.steps_taken;
    assign m_press_taken     = out_reg.press_taken;
    assign m_steps_waiting   = out_reg.steps_waiting;
    assign m_presses_waiting = out_reg.presses_waiting;
    assign m_button_stable   = out_reg.button_stable;

endmodule

>>> sv/rei_cfg.sv
module rei_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rei_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output rei_pkg::cfg_t                cfg
);

    rei_pkg::cfg_t cfg_reg;
    logic [1:0]    idx;
    logic          wr_en;

    assign idx    = paddr[3:2];
    assign wr_en  = psel & penable & pwrite & pready;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks    <= rei_pkg::DEBOUNCE_TICKS_RST;
            cfg_reg.pulses_per_detent <= rei_pkg::PULSES_PER_DETENT_RST;
            cfg_reg.button_enable     <= rei_pkg::BUTTON_ENABLE_RST;
        end else if (wr_en) begin
            case (idx)
                rei_pkg::REG_DEBOUNCE_TICKS:    cfg_reg.debounce_ticks    <= pwdata[7:0];
                rei_pkg::REG_PULSES_PER_DETENT: cfg_reg.pulses_per_detent <= pwdata[2:0];
                rei_pkg::REG_BUTTON_ENABLE:     cfg_reg.button_enable     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            rei_pkg::REG_DEBOUNCE_TICKS:    prdata = {24'd0, cfg_reg.debounce_ticks};
            rei_pkg::REG_PULSES_PER_DETENT: prdata = {29'd0, cfg_reg.pulses_per_detent};
            rei_pkg::REG_BUTTON_ENABLE:     prdata = {31'd0, cfg_reg.button_enable};
            default:                        prdata = 32'd0;
        endcase
    end

endmodule

>>> sv/rei_enc.sv
module rei_enc (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic [2:0]          pulses_per_detent,
    input  logic                pin_a,
    input  logic                pin_b,
    input  logic                take_steps,
    output logic signed [15:0]  steps_taken,
    output logic signed [15:0]  steps_waiting
);

    logic [1:0]         last_ab_reg, last_ab_next;
    logic signed [3:0]  accum_reg, accum_next;
    logic signed [15:0] steps_reg, steps_next;

    logic [1:0]         ab;
    rei_pkg::move_t     move;
    logic [2:0]         lim;
    logic signed [4:0]  lim_s;
    logic signed [4:0]  sum;
    logic signed [15:0] steps_mid;

    assign ab    = {pin_a, pin_b};
    assign move  = rei_pkg::decode_move({last_ab_reg, ab});
    assign lim   = (pulses_per_detent == 3'd0) ? 3'd1 : pulses_per_detent;
    assign lim_s = $signed({2'b00, lim});

    always_comb begin
        last_ab_next = last_ab_reg;
        accum_next   = accum_reg;
        steps_mid    = steps_reg;
        sum          = {accum_reg[3], accum_reg} + ((move == rei_pkg::MOVE_CCW) ? -5'sd1 : 5'sd1);
        if (ab != last_ab_reg) begin
            last_ab_next = ab;
            if (move == rei_pkg::MOVE_NONE) begin
                // both lines jumped: lose the partial detent
                accum_next = 4'sd0;
            end else if (sum >= lim_s) begin
                accum_next = 4'sd0;
                if (steps_reg != rei_pkg::STEPS_MAX) steps_mid = steps_reg + 16'sd1;
            end else if (sum <= -lim_s) begin
                accum_next = 4'sd0;
                if (steps_reg != rei_pkg::STEPS_MIN) steps_mid = steps_reg - 16'sd1;
            end else begin
                accum_next = sum[3:0];
            end
        end
        steps_taken = take_steps ? steps_mid : 16'sd0;
        steps_next  = take_steps ? 16'sd0 : steps_mid;
    end

    assign steps_waiting = steps_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_ab_reg <= rei_pkg::LAST_AB_RST;
            accum_reg   <= 4'sd0;
            steps_reg   <= 16'sd0;
        end else if (adv) begin
            last_ab_reg <= last_ab_next;
            accum_reg   <= accum_next;
            steps_reg   <= steps_next;
        end
    end

endmodule

>>> sv/rei_btn.sv
module rei_btn (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          adv,
    input  rei_pkg::cfg_t cfg,
    input  logic          button_pressed,
    input  logic          ms_tick,
    input  logic          take_press,
    output logic          press_taken,
    output logic [7:0]    presses_waiting,
    output logic          button_stable
);

    logic       raw_reg, raw_next;
    logic       deb_reg, deb_next;
    logic [7:0] hold_reg, hold_next;
    logic [7:0] presses_reg, presses_next;
    logic [7:0] presses_mid;

    always_comb begin
        raw_next    = raw_reg;
        deb_next    = deb_reg;
        hold_next   = hold_reg;
        presses_mid = presses_reg;
        if (cfg.button_enable) begin
            if (button_pressed != raw_reg) begin
                raw_next  = button_pressed;
                hold_next = 8'd0;
            end else if (ms_tick && hold_reg != rei_pkg::HOLD_MAX) begin
                hold_next = hold_reg + 8'd1;
            end
            if (hold_next >= cfg.debounce_ticks && button_pressed != deb_reg) begin
                deb_next = button_pressed;
                if (button_pressed && presses_reg != rei_pkg::PRESSES_MAX)
                    presses_mid = presses_reg + 8'd1;
            end
        end
        press_taken  = take_press && (presses_mid != 8'd0);
        presses_next = press_taken ? presses_mid - 8'd1 : presses_mid;
    end

    assign presses_waiting = presses_next;
    assign button_stable   = deb_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_reg     <= 1'b0;
            deb_reg     <= 1'b0;
            hold_reg    <= 8'd0;
            presses_reg <= 8'd0;
        end else if (adv) begin
            raw_reg     <= raw_next;
            deb_reg     <= deb_next;
            hold_reg    <= hold_next;
            presses_reg <= presses_next;
        end
    end

endmodule

>>> sv/rei_checker.sv
module rei_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               pready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_steps_taken,
    input logic               m_press_taken,
    input logic signed [15:0] m_steps_waiting,
    input logic [7:0]         m_presses_waiting,
    input logic               m_button_stable
);

    // a result word held back keeps its contents
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_steps_taken) && $stable(m_press_taken)
            && $stable(m_steps_waiting) && $stable(m_presses_waiting)
            && $stable(m_button_stable))
        else $error("result word changed while stalled");

    // reading the steps clears them
    a_steps_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_steps_taken != 16'sd0 |-> m_steps_waiting == 16'sd0)
        else $error("steps still pending after take");

    // a press just taken cannot leave the counter full
    a_press_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_press_taken |-> m_presses_waiting != 8'hFF)
        else $error("press taken with full press count");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

endmodule

bind rotary_encoder_interface_core rei_checker u_rei_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .pready            (pready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_steps_taken     (m_steps_taken),
    .m_press_taken     (m_press_taken),
    .m_steps_waiting   (m_steps_waiting),
    .m_presses_waiting (m_presses_waiting),
    .m_button_stable   (m_button_stable)
);
